[rtl/core/dpt_pkg.sv]
// dpt_pkg: shared types and constants of the device presence table
// used by dpt_front, dpt_queue, dpt_engine and device_presence_table_with_aging
`default_nettype none

package dpt_pkg;

    localparam int unsigned AddrW = 48;
    localparam int unsigned TimeW = 32;
    localparam int unsigned DataW = AddrW + TimeW;
    localparam logic [TimeW-1:0] DEFAULT_TIMEOUT = 32'd300;

    typedef enum logic [1:0] {
        OP_PROBE = 2'd0,
        OP_DATA  = 2'd1,
        OP_SWEEP = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        EV_REFRESHED = 3'd0,
        EV_NEW       = 3'd1,
        EV_UNKNOWN   = 3'd2,
        EV_FULL      = 3'd3,
        EV_EVICTED   = 3'd4,
        EV_DONE      = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [AddrW-1:0] mac_addr;
        logic [TimeW-1:0] time_sec;
    } t_cmd;

    typedef struct packed {
        t_event           event_res;
        logic [AddrW-1:0] dev_addr;
        logic [TimeW-1:0] idle_sec;
        logic             last;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/dpt_front.sv]
// dpt_front: input stage, decodes the request kind and holds one command
// depends on dpt_pkg; feeds dpt_queue
`default_nettype none

module dpt_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [1:0]                  s_axis_tuser,  // req_type
    input  wire logic [dpt_pkg::DataW-1:0]   s_axis_tdata,  // mac_addr, time_sec
    output logic                             o_push,
    output dpt_pkg::t_cmd                    o_push_cmd,
    input  wire logic                        i_full
);

    logic          r_valid, n_valid;
    dpt_pkg::t_cmd r_cmd, n_cmd;
    logic          accept;
    logic          known;
    dpt_pkg::t_op  op;

    always_comb begin
        known = 1'b1;
        op    = dpt_pkg::OP_PROBE;
        unique case (s_axis_tuser)
            dpt_pkg::OP_PROBE: op = dpt_pkg::OP_PROBE;
            dpt_pkg::OP_DATA:  op = dpt_pkg::OP_DATA;
            dpt_pkg::OP_SWEEP: op = dpt_pkg::OP_SWEEP;
            default: known = 1'b0;
        endcase
    end

    assign s_axis_tready = !r_valid || !i_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_push        = r_valid && !i_full;
    assign o_push_cmd    = r_cmd;

    always_comb begin
        n_valid = r_valid && !o_push;
        n_cmd   = r_cmd;
        if (accept && known) begin
            n_valid          = 1'b1;
            n_cmd.op         = op;
            n_cmd.mac_addr   = s_axis_tdata[dpt_pkg::AddrW-1:0];
            n_cmd.time_sec   = s_axis_tdata[dpt_pkg::DataW-1:dpt_pkg::AddrW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule

`default_nettype wire

[rtl/core/dpt_queue.sv]
// dpt_queue: two-entry command queue between front and engine
// depends on dpt_pkg
`default_nettype none

module dpt_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire dpt_pkg::t_cmd i_push_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output dpt_pkg::t_cmd      o_pop_cmd,
    output logic               o_empty
);

    dpt_pkg::t_cmd r_slot [2];
    logic          r_wptr, r_rptr;
    logic [1:0]    r_count;

    assign o_full    = (r_count == 2'd2);
    assign o_empty   = (r_count == 2'd0);
    assign o_pop_cmd = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_slot[r_wptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/core/dpt_engine.sv]
// dpt_engine: table scan engine, one entry per cycle unless an eviction waits on the result register
// depends on dpt_pkg; pops commands from dpt_queue
`default_nettype none

module dpt_engine #(
    parameter int unsigned TABLE_ENTRIES = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [dpt_pkg::TimeW-1:0]   i_timeout,
    input  wire logic                        i_empty,
    input  wire dpt_pkg::t_cmd               i_cmd,
    output logic                             o_pop,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output dpt_pkg::t_result                 o_result
);

    localparam int unsigned IW = $clog2(TABLE_ENTRIES);
    localparam logic [IW-1:0] LastIdx = IW'(TABLE_ENTRIES - 1);

    logic [dpt_pkg::AddrW-1:0] mem_addr [TABLE_ENTRIES];
    logic [dpt_pkg::TimeW-1:0] mem_time [TABLE_ENTRIES];
    logic [dpt_pkg::AddrW-1:0] r_rd_addr;
    logic [dpt_pkg::TimeW-1:0] r_rd_time;

    dpt_pkg::t_state           r_state, n_state;
    dpt_pkg::t_cmd             r_cmd, n_cmd;
    logic [IW-1:0]             r_chk, n_chk;
    logic                      r_hit, n_hit;
    logic [IW-1:0]             r_slot, n_slot;
    logic                      r_free_found, n_free_found;
    logic [IW-1:0]             r_free_idx, n_free_idx;
    logic [TABLE_ENTRIES-1:0]  r_valid, n_valid;
    logic                      r_out_valid, n_out_valid;
    dpt_pkg::t_result          r_out, n_out;

    logic [IW-1:0]             rd_idx;
    logic                      we;
    logic [IW-1:0]             wa;
    logic                      out_free;
    logic [dpt_pkg::TimeW-1:0] idle;
    logic                      evict;
    logic                      hit;

    assign out_free = !r_out_valid || i_ready;
    assign idle     = r_cmd.time_sec - r_rd_time;
    assign evict    = r_valid[r_chk] && (idle > i_timeout);
    assign hit      = r_valid[r_chk] && (r_rd_addr == r_cmd.mac_addr);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_chk        = r_chk;
        n_hit        = r_hit;
        n_slot       = r_slot;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_valid      = r_valid;
        n_out_valid  = r_out_valid && !i_ready;
        n_out        = r_out;
        o_pop        = 1'b0;
        we           = 1'b0;
        wa           = r_slot;
        rd_idx       = '0;
        unique case (r_state)
            dpt_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    o_pop        = 1'b1;
                    n_cmd        = i_cmd;
                    n_chk        = '0;
                    n_hit        = 1'b0;
                    n_free_found = 1'b0;
                    n_state      = dpt_pkg::ST_SCAN;
                end
            end
            dpt_pkg::ST_SCAN: begin
                rd_idx = r_chk;
                if (r_cmd.op == dpt_pkg::OP_SWEEP) begin
                    if (!evict || out_free) begin
                        if (evict) begin
                            n_valid[r_chk]  = 1'b0;
                            n_out_valid     = 1'b1;
                            n_out.event_res = dpt_pkg::EV_EVICTED;
                            n_out.dev_addr  = r_rd_addr;
                            n_out.idle_sec  = idle;
                            n_out.last      = 1'b0;
                        end
                        if (r_chk == LastIdx) begin
                            n_state = dpt_pkg::ST_DONE;
                        end else begin
                            n_chk  = r_chk + IW'(1);
                            rd_idx = r_chk + IW'(1);
                        end
                    end
                end else if (hit) begin
                    n_hit   = 1'b1;
                    n_slot  = r_chk;
                    n_state = dpt_pkg::ST_RESULT;
                end else begin
                    if (!r_valid[r_chk] && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_chk;
                    end
                    if (r_chk == LastIdx) begin
                        n_state = dpt_pkg::ST_RESULT;
                    end else begin
                        n_chk  = r_chk + IW'(1);
                        rd_idx = r_chk + IW'(1);
                    end
                end
            end
            dpt_pkg::ST_RESULT: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out.dev_addr = r_cmd.mac_addr;
                    n_out.idle_sec = '0;
                    n_out.last     = 1'b1;
                    if (r_hit) begin
                        n_out.event_res = dpt_pkg::EV_REFRESHED;
                        we              = 1'b1;
                        wa              = r_slot;
                    end else if (r_cmd.op == dpt_pkg::OP_PROBE) begin
                        if (r_free_found) begin
                            n_out.event_res     = dpt_pkg::EV_NEW;
                            we                  = 1'b1;
                            wa                  = r_free_idx;
                            n_valid[r_free_idx] = 1'b1;
                        end else begin
                            n_out.event_res = dpt_pkg::EV_FULL;
                        end
                    end else begin
                        n_out.event_res = dpt_pkg::EV_UNKNOWN;
                    end
                    n_state = dpt_pkg::ST_IDLE;
                end
            end
            dpt_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.event_res = dpt_pkg::EV_DONE;
                    n_out.dev_addr  = '0;
                    n_out.idle_sec  = '0;
                    n_out.last      = 1'b1;
                    n_state         = dpt_pkg::ST_IDLE;
                end
            end
            default: n_state = dpt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dpt_pkg::ST_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_chk        <= n_chk;
        r_hit        <= n_hit;
        r_slot       <= n_slot;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_out        <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_addr[wa] <= r_cmd.mac_addr;
            mem_time[wa] <= r_cmd.time_sec;
        end
        r_rd_addr <= mem_addr[rd_idx];
        r_rd_time <= mem_time[rd_idx];
    end

endmodule

`default_nettype wire

[rtl/core/device_presence_table_with_aging.sv]
// device presence table with aging: lookup, insert, refresh and timed eviction
// transactions are limited by the one-entry-per-cycle table scan and by any
// wait of a result for m_axis_tready
// the front stage and the two-entry queue hold up to three transactions ahead of the scan
// reset: all entries invalid at once, timeout back to 300, no clearing pass
`default_nettype none

module device_presence_table_with_aging #(
    parameter int unsigned TABLE_ENTRIES = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [1:0]                  s_axis_tuser,  // req_type
    input  wire logic [dpt_pkg::DataW-1:0]   s_axis_tdata,  // mac_addr, time_sec
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [2:0]                       m_axis_tuser,  // event_res
    output logic [dpt_pkg::DataW-1:0]        m_axis_tdata,  // dev_addr, idle_sec
    output logic                             m_axis_tlast,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [dpt_pkg::TimeW-1:0]   i_cfg_data
);

    logic [dpt_pkg::TimeW-1:0] r_timeout;
    logic                      push, full, pop, empty;
    dpt_pkg::t_cmd             push_cmd, pop_cmd;
    dpt_pkg::t_result          result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= dpt_pkg::DEFAULT_TIMEOUT;
        end else if (i_cfg_valid) begin
            r_timeout <= i_cfg_data;
        end
    end

    dpt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .o_push        (push),
        .o_push_cmd    (push_cmd),
        .i_full        (full)
    );

    dpt_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (full),
        .i_pop      (pop),
        .o_pop_cmd  (pop_cmd),
        .o_empty    (empty)
    );

    dpt_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_timeout (r_timeout),
        .i_empty   (empty),
        .i_cmd     (pop_cmd),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (result)
    );

    assign m_axis_tuser = result.event_res;
    assign m_axis_tdata = {result.idle_sec, result.dev_addr};
    assign m_axis_tlast = result.last;

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == dpt_pkg::EV_DONE |-> m_axis_tlast)
        else $error("sweep done result without tlast");

    a_evict_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == dpt_pkg::EV_EVICTED
        |-> !m_axis_tlast && (m_axis_tdata[dpt_pkg::DataW-1:dpt_pkg::AddrW] > r_timeout))
        else $error("eviction result with bad idle time or tlast");

    a_other_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != dpt_pkg::EV_EVICTED
        |-> m_axis_tlast && m_axis_tdata[dpt_pkg::DataW-1:dpt_pkg::AddrW] == '0)
        else $error("non-eviction result with idle time or without tlast");

endmodule

`default_nettype wire

[test/presence_event_checker.sv]
// presence_event_checker: watches the input, result and config channels of the presence table,
// predicts table events per accepted transaction and compares each result in arrival order
// depends on dpt_pkg for widths, request codes, event codes and the result struct
`timescale 1ns / 100ps

module presence_event_checker #(
    parameter int unsigned TABLE_ENTRIES = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    input  wire logic                        i_s_tready,
    input  wire logic [1:0]                  i_s_tuser,   // req_type
    input  wire logic [dpt_pkg::DataW-1:0]   i_s_tdata,   // mac_addr, time_sec
    input  wire logic                        i_m_tvalid,
    input  wire logic                        i_m_tready,
    input  wire logic [2:0]                  i_m_tuser,   // event_res
    input  wire logic [dpt_pkg::DataW-1:0]   i_m_tdata,   // dev_addr, idle_sec
    input  wire logic                        i_m_tlast,
    input  wire logic                        i_cfg_valid,
    input  wire logic                        i_cfg_ready,
    input  wire logic [dpt_pkg::TimeW-1:0]   i_cfg_data,
    output int                               o_errors,
    output int                               o_pending
);

    localparam int REPORT_LIMIT = 10;

    logic                      slot_live [TABLE_ENTRIES];
    logic [dpt_pkg::AddrW-1:0] slot_addr [TABLE_ENTRIES];
    logic [dpt_pkg::TimeW-1:0] slot_seen [TABLE_ENTRIES];
    logic [dpt_pkg::TimeW-1:0] idle_timeout;
    dpt_pkg::t_result          expected_events [$];
    int                        mismatch_count = 0;
    int                        result_count = 0;

    function automatic void add_event(input dpt_pkg::t_event ev,
                                      input logic [dpt_pkg::AddrW-1:0] addr,
                                      input logic [dpt_pkg::TimeW-1:0] idle, input logic last);
        dpt_pkg::t_result r;
        r.event_res = ev;
        r.dev_addr  = addr;
        r.idle_sec  = idle;
        r.last      = last;
        expected_events.push_back(r);
    endfunction

    function automatic void predict_table_events(input logic [1:0] op,
                                                 input logic [dpt_pkg::AddrW-1:0] mac,
                                                 input logic [dpt_pkg::TimeW-1:0] now);
        int                        hit;
        int                        free_slot;
        logic [dpt_pkg::TimeW-1:0] idle;
        hit = -1;
        free_slot = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (hit < 0 && slot_live[i] && slot_addr[i] == mac) hit = i;
            if (free_slot < 0 && !slot_live[i]) free_slot = i;
        end
        case (op)
            dpt_pkg::OP_PROBE: begin
                if (hit >= 0) begin
                    slot_seen[hit] = now;
                    add_event(dpt_pkg::EV_REFRESHED, mac, '0, 1'b1);
                end else if (free_slot < 0) begin
                    add_event(dpt_pkg::EV_FULL, mac, '0, 1'b1);
                end else begin
                    slot_live[free_slot] = 1'b1;
                    slot_addr[free_slot] = mac;
                    slot_seen[free_slot] = now;
                    add_event(dpt_pkg::EV_NEW, mac, '0, 1'b1);
                end
            end
            dpt_pkg::OP_DATA: begin
                if (hit >= 0) begin
                    slot_seen[hit] = now;
                    add_event(dpt_pkg::EV_REFRESHED, mac, '0, 1'b1);
                end else begin
                    add_event(dpt_pkg::EV_UNKNOWN, mac, '0, 1'b1);
                end
            end
            dpt_pkg::OP_SWEEP: begin
                // idle time wraps modulo 2^32, evictions in slot order
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    idle = now - slot_seen[i];
                    if (slot_live[i] && idle > idle_timeout) begin
                        slot_live[i] = 1'b0;
                        add_event(dpt_pkg::EV_EVICTED, slot_addr[i], idle, 1'b0);
                    end
                end
                add_event(dpt_pkg::EV_DONE, '0, '0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        dpt_pkg::t_result exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                slot_live[i] = 1'b0;
                slot_addr[i] = '0;
                slot_seen[i] = '0;
            end
            idle_timeout = dpt_pkg::DEFAULT_TIMEOUT;
            expected_events.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) idle_timeout = i_cfg_data;
            if (i_s_tvalid && i_s_tready) begin
                predict_table_events(i_s_tuser, i_s_tdata[dpt_pkg::AddrW-1:0],
                                     i_s_tdata[dpt_pkg::DataW-1:dpt_pkg::AddrW]);
            end
            if (i_m_tvalid && i_m_tready) begin
                result_count++;
                if (expected_events.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT) begin
                        $display("check: result %0d unexpected: ev=%0d addr=%h idle=%0d last=%b",
                                 result_count, i_m_tuser, i_m_tdata[dpt_pkg::AddrW-1:0],
                                 i_m_tdata[dpt_pkg::DataW-1:dpt_pkg::AddrW], i_m_tlast);
                    end
                    mismatch_count++;
                end else begin
                    exp_r = expected_events.pop_front();
                    if (i_m_tuser !== exp_r.event_res
                        || i_m_tdata[dpt_pkg::AddrW-1:0] !== exp_r.dev_addr
                        || i_m_tdata[dpt_pkg::DataW-1:dpt_pkg::AddrW] !== exp_r.idle_sec
                        || i_m_tlast !== exp_r.last) begin
                        if (mismatch_count < REPORT_LIMIT) begin
                            $display("check: result %0d expected ev=%0d addr=%h idle=%0d last=%b",
                                     result_count, exp_r.event_res, exp_r.dev_addr,
                                     exp_r.idle_sec, exp_r.last);
                            $display("check: result %0d got      ev=%0d addr=%h idle=%0d last=%b",
                                     result_count, i_m_tuser, i_m_tdata[dpt_pkg::AddrW-1:0],
                                     i_m_tdata[dpt_pkg::DataW-1:dpt_pkg::AddrW], i_m_tlast);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
        o_errors  <= mismatch_count;
        o_pending <= expected_events.size();
    end

endmodule

[test/device_presence_table_with_aging_test.sv]
// device_presence_table_with_aging_test: clock, reset, stimulus and verdict for the presence table
// depends on dpt_pkg, device_presence_table_with_aging and presence_event_checker
`timescale 1ns / 100ps

module device_presence_table_with_aging_test;

    localparam int unsigned TABLE_ENTRIES  = 32;
    localparam int          POOL_SIZE      = 40;
    localparam int          SETTLE_CYCLES  = 200;
    localparam int          RX_HOLD_CYCLES = 3000;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam logic [1:0]  OP_RESERVED    = 2'd3;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [1:0]                s_axis_tuser;   // req_type
    logic [dpt_pkg::DataW-1:0] s_axis_tdata;   // mac_addr, time_sec
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [2:0]                m_axis_tuser;   // event_res
    logic [dpt_pkg::DataW-1:0] m_axis_tdata;   // dev_addr, idle_sec
    logic                      m_axis_tlast;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [dpt_pkg::TimeW-1:0] i_cfg_data;

    int                        mismatch_total;
    int                        outstanding_events;
    logic                      rx_hold_req = 1'b0;
    int                        quiet_cycles = 0;
    int                        burst_left = 0;
    logic [dpt_pkg::TimeW-1:0] now_sec;
    logic [dpt_pkg::AddrW-1:0] mac_pool [POOL_SIZE];

    always #10 i_clk = ~i_clk;

    device_presence_table_with_aging #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    presence_event_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tuser   (s_axis_tuser),
        .i_s_tdata   (s_axis_tdata),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tuser   (m_axis_tuser),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tlast   (m_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (mismatch_total),
        .o_pending   (outstanding_events)
    );

    function automatic logic [dpt_pkg::AddrW-1:0] rand_mac();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[dpt_pkg::AddrW-1:0];
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [dpt_pkg::AddrW-1:0] mac,
                             input logic [dpt_pkg::TimeW-1:0] ts);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 80 : 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {ts, mac};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding_events != 0) @(posedge i_clk);
        // a reserved request gives no result; the front stage drops it
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idle_timeout(input logic [dpt_pkg::TimeW-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_item();
        int                        pick;
        logic [dpt_pkg::AddrW-1:0] mac;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 49) == 0) now_sec = $urandom();
        else now_sec += $urandom_range(0, 120);
        mac = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (pick < 45) send_item(dpt_pkg::OP_PROBE, mac, now_sec);
        else if (pick < 50) send_item(dpt_pkg::OP_PROBE, rand_mac(), now_sec);
        else if (pick < 72) send_item(dpt_pkg::OP_DATA, mac, now_sec);
        else if (pick < 77) send_item(dpt_pkg::OP_DATA, rand_mac(), now_sec);
        else if (pick < 93) send_item(dpt_pkg::OP_SWEEP, rand_mac(), now_sec);
        else send_item(OP_RESERVED, rand_mac(), $urandom());
    endtask

    task automatic run_random_phase(input int count);
        for (int i = 0; i < 8; i++) mac_pool[$urandom_range(0, POOL_SIZE - 1)] = rand_mac();
        for (int i = 0; i < count; i++) send_random_item();
    endtask

    // receiver: random ready patterns, plus one long hold-off on request
    initial begin : rx_side
        int mode_left;
        int ready_pct;
        bit held;
        mode_left = 0;
        ready_pct = 100;
        held = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req && !held) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode_left = $urandom_range(16, 160);
                    case ($urandom_range(0, 3))
                        0: ready_pct = 100;
                        1: ready_pct = 70;
                        2: ready_pct = 40;
                        default: ready_pct = 10;
                    endcase
                end
                mode_left--;
                m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= '0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, timeout at its reset value
        send_item(dpt_pkg::OP_SWEEP, '0, '0);
        send_item(dpt_pkg::OP_DATA, '0, 32'd0);
        send_item(dpt_pkg::OP_PROBE, '0, 32'd0);
        send_item(dpt_pkg::OP_PROBE, '1, '1);
        send_item(dpt_pkg::OP_PROBE, '0, 32'd100);
        send_item(dpt_pkg::OP_DATA, '1, 32'd5);
        send_item(OP_RESERVED, '1, '1);
        send_item(dpt_pkg::OP_SWEEP, '1, 32'd400);
        send_item(dpt_pkg::OP_PROBE, 48'h5555_5555_5555, 32'hFFFF_FFF0);
        send_item(dpt_pkg::OP_SWEEP, '0, 32'd10);
        send_item(dpt_pkg::OP_PROBE, 48'hAAAA_AAAA_AAAA, 32'd20);
        send_item(dpt_pkg::OP_DATA, 48'h5555_5555_5555, 32'd20);
        send_item(dpt_pkg::OP_SWEEP, '0, 32'd321);

        now_sec = $urandom();
        for (int i = 0; i < POOL_SIZE; i++) mac_pool[i] = rand_mac();

        // no aging, fill past capacity while the receiver holds off
        set_idle_timeout('1);
        rx_hold_req <= 1'b1;
        for (int i = 0; i < POOL_SIZE; i++) begin
            now_sec += $urandom_range(0, 3);
            send_item(dpt_pkg::OP_PROBE, mac_pool[i], now_sec);
        end
        run_random_phase(60);

        set_idle_timeout('0);
        run_random_phase(70);
        set_idle_timeout($urandom_range(50, 600));
        run_random_phase(70);
        set_idle_timeout($urandom());
        run_random_phase(70);
        set_idle_timeout(dpt_pkg::DEFAULT_TIMEOUT);
        run_random_phase(70);

        wait_drained();
        if (mismatch_total == 0 && outstanding_events == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/dpt_pkg.sv
rtl/core/dpt_front.sv
rtl/core/dpt_queue.sv
rtl/core/dpt_engine.sv
rtl/core/device_presence_table_with_aging.sv
test/presence_event_checker.sv
test/device_presence_table_with_aging_test.sv
